@@ hw/rtl/cutc_pkg.sv @@
// Shared constants, a type and a table function for the calendar to Unix seconds converter.
// No dependencies.
`default_nettype none

package cutc_pkg;

  localparam int unsigned YearW    = 12;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned SecondW  = 6;
  localparam int unsigned SecsW    = 32;
  localparam int unsigned Q100W    = 6;

  localparam logic [HourW-1:0] UtcOffsetReset = 5'd9;

  localparam logic [YearW-1:0] EpochYear   = 12'd1970;
  localparam logic [11:0]      LeapsTo1969 = 12'd477;

  // floor(n / 100) for n below 4096 equals (n * Recip100) >> Recip100Shift.
  localparam logic [12:0]      Recip100      = 13'd5243;
  localparam int unsigned      Recip100Shift = 19;

  localparam logic [MonthW-1:0] FebruaryDone = 4'd2;
  localparam logic [MonthW-1:0] AllMonths    = 4'd12;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } cutc_adv_t;

  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] whole_months);
    logic [8:0] d;
    case (whole_months)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/calendar_to_unix_seconds.sv @@
// Throughput: one item per cycle while the output is not stalled; five register stages
// (year quotients, day count, hours, minutes, seconds), each with its own valid bit, so
// bubbles close up under stall.
// Reset: synchronous, clears all valid bits and sets the UTC offset to nine hours.
// Top level of the calendar to Unix seconds converter; depends on cutc_pkg, cutc_day_count.
`default_nettype none

module calendar_to_unix_seconds
  import cutc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 utc_offset_we,
  input  wire logic [HourW-1:0]     utc_offset_hours,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic [YearW-1:0]     year,
  input  wire logic [MonthW-1:0]    month,
  input  wire logic [DayW-1:0]      day_of_month,
  input  wire logic [HourW-1:0]     hour,
  input  wire logic [MinuteW-1:0]   minute,
  input  wire logic [SecondW-1:0]   second,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic      [SecsW-1:0]     unix_seconds
);

  logic [HourW-1:0]   utc_offset;
  logic [4:0]         valid;
  logic [4:0]         ready;
  cutc_adv_t          adv;

  logic [SecsW-1:0]   days;
  logic [HourW-1:0]   hour2;
  logic [MinuteW-1:0] minute2;
  logic [SecondW-1:0] second2;

  logic [SecsW-1:0]   hours;
  logic [MinuteW-1:0] minute3;
  logic [SecondW-1:0] second3;
  logic [SecsW-1:0]   minutes;
  logic [SecondW-1:0] second4;
  logic [SecsW-1:0]   total;

  always_comb begin
    ready[4] = !valid[4] || !result_stall;
    ready[3] = !valid[3] || ready[4];
    ready[2] = !valid[2] || ready[3];
    ready[1] = !valid[1] || ready[2];
    ready[0] = !valid[0] || ready[1];
    adv.ld1  = ready[0];
    adv.ld2  = ready[1];
  end

  assign item_stall   = !ready[0];
  assign result_valid = valid[4];
  assign unix_seconds = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      utc_offset <= UtcOffsetReset;
      valid      <= '0;
    end else begin
      if (utc_offset_we) begin
        utc_offset <= utc_offset_hours;
      end
      if (ready[0]) valid[0] <= item_valid;
      if (ready[1]) valid[1] <= valid[0];
      if (ready[2]) valid[2] <= valid[1];
      if (ready[3]) valid[3] <= valid[2];
      if (ready[4]) valid[4] <= valid[3];
    end
  end

  cutc_day_count u_day_count (
    .clk          (clk),
    .adv          (adv),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .days         (days),
    .hour_q       (hour2),
    .minute_q     (minute2),
    .second_q     (second2)
  );

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      hours   <= days * 32'd24 + 32'(hour2) - 32'(utc_offset);
      minute3 <= minute2;
      second3 <= second2;
    end
    if (ready[3]) begin
      minutes <= hours * 32'd60 + 32'(minute3);
      second4 <= second3;
    end
    if (ready[4]) begin
      total <= minutes * 32'd60 + 32'(second4);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cutc_day_count.sv @@
// Day count since the epoch: first two pipeline stages of the converter.
// Depends on cutc_pkg.
`default_nettype none

module cutc_day_count
  import cutc_pkg::*;
(
  input  wire logic                 clk,
  input  wire cutc_adv_t            adv,
  input  wire logic [YearW-1:0]     year,
  input  wire logic [MonthW-1:0]    month,
  input  wire logic [DayW-1:0]      day_of_month,
  input  wire logic [HourW-1:0]     hour,
  input  wire logic [MinuteW-1:0]   minute,
  input  wire logic [SecondW-1:0]   second,
  output logic      [SecsW-1:0]     days,
  output logic      [HourW-1:0]     hour_q,
  output logic      [MinuteW-1:0]   minute_q,
  output logic      [SecondW-1:0]   second_q
);

  logic [YearW-1:0]    year1;
  logic [MonthW-1:0]   month1;
  logic [DayW-1:0]     day1;
  logic [HourW-1:0]    hour1;
  logic [MinuteW-1:0]  minute1;
  logic [SecondW-1:0]  second1;
  logic [Q100W-1:0]    q100_y;
  logic [Q100W-1:0]    q100_p;

  logic [YearW-1:0]    prev_year;
  logic [24:0]         prod_y;
  logic [24:0]         prod_p;

  logic [YearW-1:0]    prev_year1;
  logic [11:0]         leaps;
  logic [YearW-1:0]    year_span;
  logic [SecsW-1:0]    year_days;
  logic [MonthW-1:0]   whole_months;
  logic                by_100;
  logic                leap;
  logic [SecsW-1:0]    days_next;

  always_comb begin
    prev_year = year - 12'd1;
    prod_y    = 25'(year) * 25'(Recip100);
    prod_p    = 25'(prev_year) * 25'(Recip100);
  end

  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      year1   <= year;
      month1  <= month;
      day1    <= day_of_month;
      hour1   <= hour;
      minute1 <= minute;
      second1 <= second;
      q100_y  <= prod_y[Recip100Shift +: Q100W];
      q100_p  <= prod_p[Recip100Shift +: Q100W];
    end
  end

  always_comb begin
    prev_year1 = year1 - 12'd1;
    leaps      = 12'(prev_year1 >> 2) - 12'(q100_p) + 12'(q100_p >> 2);
    year_span  = year1 - EpochYear;
    if (year1 > EpochYear) begin
      year_days = 32'(year_span) * 32'd365 + 32'(leaps) - 32'(LeapsTo1969);
    end else begin
      year_days = '0;
    end

    if (month1 == '0) begin
      whole_months = '0;
    end else if (month1 > AllMonths) begin
      whole_months = AllMonths;
    end else begin
      whole_months = month1 - 4'd1;
    end

    by_100 = (year1 == 12'(12'(q100_y) * 12'd100));
    leap   = (year1[1:0] == 2'd0) && (!by_100 || q100_y[1:0] == 2'd0);

    days_next = year_days + 32'(days_before_month(whole_months))
              + 32'(leap && whole_months >= FebruaryDone)
              + 32'(day1) - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      days     <= days_next;
      hour_q   <= hour1;
      minute_q <= minute1;
      second_q <= second1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cutc_checker.sv @@
// Port-level checks for calendar_to_unix_seconds, attached by the bind at the end.
// Depends on cutc_pkg.
`default_nettype none

module cutc_checker
  import cutc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire logic [SecsW-1:0] unix_seconds
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(unix_seconds))
    else $error("Stalled result changed or was dropped.");

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("Input stalled while the output stage is empty.");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("Result valid right after reset.");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(rst, 1))
    else $error("Result appeared straight out of reset.");

endmodule

bind calendar_to_unix_seconds cutc_checker u_cutc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .unix_seconds (unix_seconds)
);

`default_nettype wire
